// ===== rtl/core/http_chunked_body_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// http chunked body decoder assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HCBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// types and constants shared by the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam int SIZE_BITS = 32;

	// command queue between front and back
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = 2;

	// result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;

	// result kinds
	localparam logic [2:0] K_DATA  = 3'd0;
	localparam logic [2:0] K_ZERO  = 3'd1;
	localparam logic [2:0] K_ENDED = 3'd2;
	localparam logic [2:0] K_BAD   = 3'd3;
	localparam logic [2:0] K_TRUNC = 3'd4;

	// characters of interest
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       msg_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] out_kind;
		logic       out_last;
	} res_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] in_byte;
		logic       msg_end;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_blank;
		logic       is_cr;
		logic       is_lf;
	} cmd_t;

endpackage

// ===== rtl/core/hcbd_front.sv =====
// ----------------------------------------------------------------------------
// hcbd_front
// accepts input bytes, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module hcbd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  hcbd_pkg::in_item_t item,
	input  logic              take,
	output logic              avail,
	output hcbd_pkg::cmd_t    cmd
);
	import hcbd_pkg::*;

	cmd_t              cmd_q [CQ_DEPTH];
	logic [CQ_AW-1:0]  wr_ptr_q;
	logic [CQ_AW-1:0]  rd_ptr_q;
	logic [CQ_AW:0]    count_q;
	cmd_t              cls;
	logic              is_digit;
	logic              is_lower;
	logic              is_upper;
	logic              wr_en;
	logic              rd_en;

	always_comb begin
		is_digit = (item.in_byte >= 8'h30) && (item.in_byte <= 8'h39);
		is_lower = (item.in_byte >= 8'h61) && (item.in_byte <= 8'h66);
		is_upper = (item.in_byte >= 8'h41) && (item.in_byte <= 8'h46);
		cls.in_byte  = item.in_byte;
		cls.msg_end  = item.msg_end;
		cls.is_hex   = is_digit || is_lower || is_upper;
		// letters a-f and A-F share the low nibble 1..6
		cls.hex_val  = is_digit ? item.in_byte[3:0] : (item.in_byte[3:0] + 4'd9);
		cls.is_blank = (item.in_byte == CH_SP) || (item.in_byte == CH_TAB);
		cls.is_cr    = (item.in_byte == CH_CR);
		cls.is_lf    = (item.in_byte == CH_LF);
	end

	assign full  = (count_q == (CQ_AW+1)'(CQ_DEPTH));
	assign avail = (count_q != '0);
	assign cmd   = cmd_q[rd_ptr_q];
	assign wr_en = push && !full;
	assign rd_en = take && avail;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cmd_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/hcbd_back.sv =====
// ----------------------------------------------------------------------------
// hcbd_back
// chunk framing state machine and result queue
// ----------------------------------------------------------------------------
module hcbd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           avail,
	input  hcbd_pkg::cmd_t cmd,
	output logic           take,
	output logic           empty,
	input  logic           pop,
	output hcbd_pkg::res_t result
);
	import hcbd_pkg::*;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_LINE  = 3'd1;
	localparam logic [2:0] PH_DATA  = 3'd2;
	localparam logic [2:0] PH_SKIP  = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;
	localparam logic [2:0] PH_ERR   = 3'd5;

	logic [2:0]           phase_q, phase_n;
	logic [SIZE_BITS-1:0] size_accum_q, size_accum_n;
	logic [SIZE_BITS-1:0] bytes_left_q, bytes_left_n;
	logic                 digit_seen_q, digit_seen_n;
	logic                 number_closed_q, number_closed_n;
	logic                 cr_pending_q, cr_pending_n;
	logic [1:0]           skip_count_q, skip_count_n;
	logic [1:0]           skip_dec;

	logic                 p_v;
	logic [2:0]           p_kind;
	logic [7:0]           p_byte;
	logic                 e_v;
	logic [2:0]           e_kind;
	res_t                 slot0;
	res_t                 slot1;
	logic [1:0]           n_wr;
	logic [1:0]           n_put;

	res_t                 rq_mem [RQ_DEPTH];
	logic [RQ_AW-1:0]     rq_wr_q;
	logic [RQ_AW-1:0]     rq_rd_q;
	logic [RQ_AW:0]       rq_count_q;
	logic                 rd_en;

	// room for the worst case of two results per byte
	assign take  = avail && (rq_count_q <= (RQ_AW+1)'(RQ_DEPTH - 2));
	assign empty = (rq_count_q == '0);
	assign rd_en = pop && !empty;
	assign result = rq_mem[rq_rd_q];

	always_comb begin
		phase_n         = phase_q;
		size_accum_n    = size_accum_q;
		bytes_left_n    = bytes_left_q;
		digit_seen_n    = digit_seen_q;
		number_closed_n = number_closed_q;
		cr_pending_n    = cr_pending_q;
		skip_count_n    = skip_count_q;
		skip_dec        = (skip_count_q != 2'd0) ? (skip_count_q - 2'd1) : 2'd0;
		p_v             = 1'b0;
		p_kind          = K_DATA;
		p_byte          = 8'h00;
		e_v             = 1'b0;
		e_kind          = K_ENDED;

		case (phase_q)
			PH_START, PH_LINE: begin
				phase_n = PH_LINE;
				if (cmd.is_lf && cr_pending_q) begin
					cr_pending_n    = 1'b0;
					size_accum_n    = '0;
					digit_seen_n    = 1'b0;
					number_closed_n = 1'b0;
					if (!digit_seen_q) begin
						phase_n = PH_ERR;
						p_v     = 1'b1;
						p_kind  = K_BAD;
					end else if (size_accum_q == '0) begin
						phase_n = PH_DONE;
						p_v     = 1'b1;
						p_kind  = K_ZERO;
					end else begin
						bytes_left_n = size_accum_q;
						phase_n      = PH_DATA;
					end
				end else begin
					cr_pending_n = cmd.is_cr;
					if (!number_closed_q) begin
						if (cmd.is_hex) begin
							// top nibble busy means the next digit would overflow
							if (size_accum_q[SIZE_BITS-1 -: 4] != 4'd0) begin
								phase_n = PH_ERR;
								p_v     = 1'b1;
								p_kind  = K_BAD;
							end else begin
								size_accum_n = {size_accum_q[SIZE_BITS-5:0], cmd.hex_val};
								digit_seen_n = 1'b1;
							end
						end else if (cmd.is_blank && !digit_seen_q) begin
							phase_n = PH_LINE;
						end else begin
							number_closed_n = 1'b1;
							if (!digit_seen_q) begin
								phase_n = PH_ERR;
								p_v     = 1'b1;
								p_kind  = K_BAD;
							end
						end
					end
				end
			end
			PH_DATA: begin
				p_v          = 1'b1;
				p_kind       = K_DATA;
				p_byte       = cmd.in_byte;
				bytes_left_n = bytes_left_q - 1'b1;
				if (bytes_left_q == SIZE_BITS'(1)) begin
					phase_n      = PH_SKIP;
					skip_count_n = 2'd2;
				end
			end
			PH_SKIP: begin
				skip_count_n = skip_dec;
				if (skip_dec == 2'd0) begin
					phase_n = PH_START;
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase

		if (cmd.msg_end) begin
			if (phase_n == PH_START || phase_n == PH_SKIP) begin
				e_v    = 1'b1;
				e_kind = K_ENDED;
			end else if (phase_n == PH_LINE || phase_n == PH_DATA) begin
				e_v    = 1'b1;
				e_kind = K_TRUNC;
			end
			phase_n         = PH_START;
			size_accum_n    = '0;
			bytes_left_n    = '0;
			digit_seen_n    = 1'b0;
			number_closed_n = 1'b0;
			cr_pending_n    = 1'b0;
			skip_count_n    = 2'd0;
		end
	end

	// pack up to two results, status after payload
	always_comb begin
		slot0.out_byte = p_v ? p_byte : 8'h00;
		slot0.out_kind = p_v ? p_kind : e_kind;
		slot0.out_last = !(p_v && e_v);
		slot1.out_byte = 8'h00;
		slot1.out_kind = e_kind;
		slot1.out_last = 1'b1;
		n_wr  = {1'b0, p_v} + {1'b0, e_v};
		n_put = take ? n_wr : 2'd0;
	end

	always_ff @(posedge clk) begin
		if (n_put != 2'd0) begin
			rq_mem[rq_wr_q] <= slot0;
		end
		if (n_put == 2'd2) begin
			rq_mem[rq_wr_q + 1'b1] <= slot1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_START;
			size_accum_q    <= '0;
			bytes_left_q    <= '0;
			digit_seen_q    <= 1'b0;
			number_closed_q <= 1'b0;
			cr_pending_q    <= 1'b0;
			skip_count_q    <= 2'd0;
			rq_wr_q         <= '0;
			rq_rd_q         <= '0;
			rq_count_q      <= '0;
		end else begin
			if (take) begin
				phase_q         <= phase_n;
				size_accum_q    <= size_accum_n;
				bytes_left_q    <= bytes_left_n;
				digit_seen_q    <= digit_seen_n;
				number_closed_q <= number_closed_n;
				cr_pending_q    <= cr_pending_n;
				skip_count_q    <= skip_count_n;
			end
			rq_wr_q    <= rq_wr_q + RQ_AW'(n_put);
			if (rd_en) begin
				rq_rd_q <= rq_rd_q + 1'b1;
			end
			rq_count_q <= rq_count_q + (RQ_AW+1)'(n_put) - (RQ_AW+1)'(rd_en);
		end
	end

endmodule

// ===== rtl/core/http_chunked_body_decoder.sv =====
// Chunked HTTP body decoder. One body byte is taken per cycle whenever full is
// low; the front classifies it into a four-entry command queue and the back
// runs the chunk framing on one queued byte per cycle, so throughput is one
// byte per clock while the result side keeps pace. A byte yields up to two
// results (a payload or status result, then an end-of-message status); the
// result queue drains one per pop, so a byte that yields two results needs two
// pops on the result side.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// top level: classifying front, command queue, framing back and result queue
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  hcbd_pkg::in_item_t item,
	output logic               empty,
	input  logic               pop,
	output hcbd_pkg::res_t     result
);
	import hcbd_pkg::*;

	cmd_t cmd;
	logic avail;
	logic take;

	hcbd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.take   (take),
		.avail  (avail),
		.cmd    (cmd)
	);

	hcbd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.cmd    (cmd),
		.take   (take),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

// ===== rtl/core/hcbd_checker.sv =====
// ----------------------------------------------------------------------------
// hcbd_checker
// port level checks on the result stream of the decoder
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_defines.svh"

module hcbd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input hcbd_pkg::res_t     result
);
	import hcbd_pkg::*;

	logic in_xfer;
	logic out_wait;
	logic kind_ok;
	logic status_out;

	assign in_xfer    = push && !full;
	assign out_wait   = !empty && !pop;
	assign kind_ok    = (result.out_kind == K_DATA) || (result.out_kind == K_ZERO)
		|| (result.out_kind == K_ENDED) || (result.out_kind == K_BAD)
		|| (result.out_kind == K_TRUNC);
	assign status_out = !empty && (result.out_kind != K_DATA);

	// the command queue only fills through an input transfer
	`HCBD_ASSERT_NEXT(a_full_needs_xfer, !full && !in_xfer, !full, "full rose without a transfer")
	// a waiting result holds until its transfer
	`HCBD_ASSERT_NEXT(a_result_holds, out_wait, !empty && $stable(result), "result changed early")
	`HCBD_ASSERT_NOW(a_kind_legal, !empty, kind_ok, "illegal result kind")
	`HCBD_ASSERT_NOW(a_status_byte_zero, status_out, result.out_byte == 8'h00, "status has a byte")
	// every status closes the results of its byte
	`HCBD_ASSERT_NOW(a_status_is_last, status_out, result.out_last, "status result not marked last")

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

// ===== dv/tb_http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// self-checking bench: chunked bodies go in one byte per transfer and a
// byte-level decoder model predicts every result, which is compared field by
// field as results are popped, under several mixes of sender and receiver idling
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;
	import hcbd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;

	typedef enum logic [2:0] {
		SCAN_BOL,
		SCAN_SIZE,
		PASS_DATA,
		SKIP_CRLF,
		BODY_DONE,
		BODY_BAD
	} frame_phase_t;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     push   = 1'b0;
	logic     full;
	in_item_t item   = '0;
	logic     empty;
	logic     pop    = 1'b0;
	res_t     result;

	// decoder model state
	frame_phase_t         parse_phase;
	logic [SIZE_BITS-1:0] size_acc;
	logic [SIZE_BITS-1:0] data_left;
	logic                 have_digit;
	logic                 num_closed;
	logic                 saw_cr;
	logic [1:0]           trail_left;

	res_t       pending_results [$];
	res_t       want;
	logic [7:0] msg_buf [$];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int cycles;
	int bytes_sent;
	int framed_bytes;
	int messages;
	int kind_count [5];

	http_chunked_body_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int hex_digit_value(input logic [7:0] b);
		if (b >= "0" && b <= "9") return int'(b - "0");
		if (b >= "a" && b <= "f") return int'(b - "a") + 10;
		if (b >= "A" && b <= "F") return int'(b - "A") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return 8'("0") + 8'(nib);
		return ($urandom_range(1) ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	// append one byte to the message being built
	task automatic add_byte(input logic [7:0] b);
		msg_buf.insert(msg_buf.size(), b);
	endtask

	task automatic expect_result(input logic [7:0] b, input logic [2:0] kind);
		res_t r;
		r.out_byte = b;
		r.out_kind = kind;
		r.out_last = 1'b0;
		pending_results.insert(pending_results.size(), r);
	endtask

	task automatic clear_decoder();
		parse_phase = SCAN_BOL;
		size_acc    = '0;
		data_left   = '0;
		have_digit  = 1'b0;
		num_closed  = 1'b0;
		saw_cr      = 1'b0;
		trail_left  = 2'd0;
	endtask

	// model of the framing for one accepted byte
	task automatic decode_byte(input logic [7:0] b, input logic e);
		int d;
		int n0;
		n0 = pending_results.size();
		if (parse_phase != BODY_DONE && parse_phase != BODY_BAD)
			framed_bytes++;
		case (parse_phase)
		SCAN_BOL, SCAN_SIZE: begin
			parse_phase = SCAN_SIZE;
			if (b == CH_LF && saw_cr) begin
				saw_cr = 1'b0;
				if (!have_digit) begin
					parse_phase = BODY_BAD;
					expect_result(8'h00, K_BAD);
				end else if (size_acc == '0) begin
					parse_phase = BODY_DONE;
					expect_result(8'h00, K_ZERO);
				end else begin
					data_left   = size_acc;
					parse_phase = PASS_DATA;
				end
				size_acc   = '0;
				have_digit = 1'b0;
				num_closed = 1'b0;
			end else begin
				saw_cr = (b == CH_CR);
				if (!num_closed) begin
					d = hex_digit_value(b);
					if (d >= 0) begin
						if (size_acc[SIZE_BITS-1 -: 4] != 4'h0) begin
							parse_phase = BODY_BAD;
							expect_result(8'h00, K_BAD);
						end else begin
							size_acc   = {size_acc[SIZE_BITS-5:0], 4'(d)};
							have_digit = 1'b1;
						end
					end else if ((b == CH_SP || b == CH_TAB) && !have_digit) begin
						// leading blank, skipped
					end else begin
						num_closed = 1'b1;
						if (!have_digit) begin
							parse_phase = BODY_BAD;
							expect_result(8'h00, K_BAD);
						end
					end
				end
			end
		end
		PASS_DATA: begin
			expect_result(b, K_DATA);
			data_left = data_left - 1'b1;
			if (data_left == '0) begin
				parse_phase = SKIP_CRLF;
				trail_left  = 2'd2;
			end
		end
		SKIP_CRLF: begin
			if (trail_left != 2'd0)
				trail_left = trail_left - 1'b1;
			if (trail_left == 2'd0)
				parse_phase = SCAN_BOL;
		end
		default: ;
		endcase
		if (e) begin
			if (parse_phase == SCAN_BOL || parse_phase == SKIP_CRLF)
				expect_result(8'h00, K_ENDED);
			else if (parse_phase == SCAN_SIZE || parse_phase == PASS_DATA)
				expect_result(8'h00, K_TRUNC);
			clear_decoder();
		end
		if (pending_results.size() > n0)
			pending_results[pending_results.size()-1].out_last = 1'b1;
	endtask

	// push stays high between back-to-back transfers
	task automatic push_body_byte(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= {b, e};
		@(posedge clk);
		while (full) @(posedge clk);
		decode_byte(b, e);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input logic end_last);
		int i;
		for (i = 0; i < s.len(); i++)
			push_body_byte(s[i], end_last && (i == s.len() - 1));
	endtask

	task automatic send_msg_buf();
		int i;
		for (i = 0; i < msg_buf.size(); i++)
			push_body_byte(msg_buf[i], i == msg_buf.size() - 1);
		messages++;
	endtask

	task automatic add_hex(input logic [SIZE_BITS-1:0] v, input int min_digits);
		int nd;
		int i;
		nd = 1;
		while (nd < SIZE_BITS / 4 && (v >> (4 * nd)) != '0) nd++;
		if (nd < min_digits) nd = min_digits;
		for (i = nd - 1; i >= 0; i--)
			add_byte(hex_char((i < SIZE_BITS / 4) ? v[4*i +: 4] : 4'h0));
	endtask

	task automatic add_size_line(input logic [SIZE_BITS-1:0] v);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) add_byte($urandom_range(1) ? CH_SP : CH_TAB);
		add_hex(v, ($urandom_range(7) == 0) ? $urandom_range(2, 10) : 1);
		// chunk extension
		if ($urandom_range(3) == 0) begin
			add_byte(";");
			repeat ($urandom_range(0, 6)) add_byte(plain_byte());
		end
		// lone cr that must not end the line
		if ($urandom_range(7) == 0) begin
			add_byte(CH_CR);
			add_byte(plain_byte());
		end
		add_byte(CH_CR);
		add_byte(CH_LF);
	endtask

	task automatic send_random_message();
		int pick;
		int sz;
		int cut;
		logic [7:0] b;
		msg_buf.delete();
		pick = $urandom_range(99);
		if (pick < 90) begin
			repeat ($urandom_range(0, 3)) begin
				sz = ($urandom_range(9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
				add_size_line(sz);
				repeat (sz) add_byte(8'($urandom_range(255)));
				if ($urandom_range(9) == 0) begin
					add_byte(8'($urandom_range(255)));
					add_byte(8'($urandom_range(255)));
				end else begin
					add_byte(CH_CR);
					add_byte(CH_LF);
				end
			end
		end
		if (pick < 75 || (pick >= 85 && pick < 90)) begin
			add_size_line('0);
			if (pick < 60 ? $urandom_range(1) : 1) begin
				add_byte(CH_CR);
				add_byte(CH_LF);
			end
			if (pick >= 85)
				repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
			if (pick >= 60 && pick < 75) begin
				cut = $urandom_range(1, msg_buf.size());
				while (msg_buf.size() > cut) msg_buf.delete(msg_buf.size() - 1);
			end
		end else if (pick < 85) begin
			if ($urandom_range(1)) begin
				// size line without digits
				if ($urandom_range(1)) add_byte(CH_SP);
				if ($urandom_range(4) == 0) begin
					b = CH_CR;
				end else begin
					do b = plain_byte();
					while (hex_digit_value(b) >= 0 || b == CH_SP || b == CH_TAB);
				end
				add_byte(b);
			end else begin
				// one digit more than the count can hold
				add_byte(hex_char(4'($urandom_range(1, 15))));
				repeat (SIZE_BITS / 4) add_byte(hex_char(4'($urandom_range(15))));
			end
			repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(3))
				0: add_byte(8'($urandom_range(255)));
				1: add_byte(hex_char(4'($urandom_range(15))));
				2: add_byte($urandom_range(1) ? CH_CR : CH_LF);
				default: add_byte($urandom_range(1) ? CH_SP : CH_TAB);
				endcase
			end
		end
		send_msg_buf();
	endtask

	task automatic flag_mismatch(input string why, input res_t exp_r);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t %s: expected byte %02h kind %0d last %0d, %s %02h kind %0d last %0d",
				$realtime, why, exp_r.out_byte, exp_r.out_kind, exp_r.out_last,
				"got byte", result.out_byte, result.out_kind, result.out_last);
	endtask

	// result side: check each transfer, then choose pop for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("unexpected result", '0);
				end else begin
					want = pending_results.pop_front();
					if (result.out_byte !== want.out_byte || result.out_kind !== want.out_kind
							|| result.out_last !== want.out_last)
						flag_mismatch("result mismatch", want);
					if (want.out_kind <= K_TRUNC)
						kind_count[want.out_kind]++;
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic test_chunk_framing();
		// blanks, extension and a lone cr before the real line end
		send_text(" \t1;z\015x\015\012", 1'b0);
		push_body_byte(8'hff, 1'b0);
		push_body_byte(8'h00, 1'b0);
		push_body_byte(8'h80, 1'b1);
	endtask

	task automatic test_size_overflow();
		send_text("aBcDeF09", 1'b0);
		push_body_byte("1", 1'b1);
	endtask

	task automatic test_missing_digits();
		push_body_byte(CH_CR, 1'b0);
		push_body_byte(CH_LF, 1'b1);
	endtask

	task automatic test_zero_chunk();
		send_text("0\015\012\015\012", 1'b1);
	endtask

	task automatic test_truncation();
		push_body_byte("7", 1'b1);
		send_text("2\015\012", 1'b1);
	endtask

	task automatic test_random_messages(input int idle_pct, input int stall_pct, input int n);
		int start;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = bytes_sent;
		while (bytes_sent - start < n) send_random_message();
	endtask

	initial begin
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		mismatches     = 0;
		cycles         = 0;
		bytes_sent     = 0;
		framed_bytes   = 0;
		messages       = 0;
		kind_count     = '{default: 0};
		clear_decoder();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_chunk_framing();
		test_size_overflow();
		test_missing_digits();
		test_zero_chunk();
		test_truncation();
		test_random_messages(0, 0, 450);
		test_random_messages(64, 0, 450);
		test_random_messages(0, 64, 450);
		test_random_messages(23, 23, 450);

		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d bytes (%0d framed) in %0d random messages plus directed cases",
			bytes_sent, framed_bytes, messages);
		$display("checked %0d data, %0d zero-size ends, %0d between-chunk ends, %s",
			kind_count[K_DATA], kind_count[K_ZERO], kind_count[K_ENDED],
			$sformatf("%0d bad sizes, %0d truncations",
				kind_count[K_BAD], kind_count[K_TRUNC]));
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== http_chunked_body_decoder.f =====
+incdir+rtl/core
rtl/core/hcbd_pkg.sv
rtl/core/hcbd_front.sv
rtl/core/hcbd_back.sv
rtl/core/http_chunked_body_decoder.sv
rtl/core/hcbd_checker.sv
dv/tb_http_chunked_body_decoder.sv
